### src/ground_line_below_point_query_macros.svh
// Assertion macros for the ground line query block.
// Included by the top level; needs a clock named aclk and reset aresetn in scope.
`ifndef GROUND_LINE_BELOW_POINT_QUERY_MACROS_SVH
`define GROUND_LINE_BELOW_POINT_QUERY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GLBPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define GLBPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define GLBPQ_ASSERT(lbl, prop, msg)
`define GLBPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### src/glbpq_pkg.sv
// Shared types and constants of the ground line query block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package glbpq_pkg;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int TOL_W    = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd2560;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOLINE = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CHECK, S_DIV, S_FINISH, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        D_IDLE, D_MUL, D_RUN
    } div_state_t;

    // handshake between sequencer and the mul-div unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage
`default_nettype wire

### src/glbpq_muldiv.sv
// Iterative unit: floor(a * b / d), one product then one quotient bit per cycle.
// Depends on glbpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module glbpq_muldiv #(
    parameter int W = 25
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [W-1:0]        a,
    input  wire logic [W-1:0]        b,
    input  wire logic [W-1:0]        d,
    output glbpq_pkg::div_ctl_t      ctl,
    output logic      [W-1:0]        quot
);
    import glbpq_pkg::*;

    localparam int PW = 2 * W;
    localparam int CW = $clog2(PW);

    div_state_t      state_reg, state_next;
    logic [W-1:0]    a_reg, b_reg, d_reg;
    logic [PW-1:0]   prod_reg, prod_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    quot_reg, quot_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [W:0]      rem_shift, rem_diff;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
            d_reg <= d;
        end
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
    end

    // restoring division step
    assign rem_shift = {rem_reg, prod_reg[PW-1]};
    assign rem_diff  = rem_shift - {1'b0, d_reg};

    always_comb begin
        state_next = state_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            D_IDLE: begin
                if (start) state_next = D_MUL;
            end
            D_MUL: begin
                // full-width product of the two operands
                prod_next  = {{W{1'b0}}, a_reg} * {{W{1'b0}}, b_reg};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = D_RUN;
            end
            D_RUN: begin
                prod_next = {prod_reg[PW-2:0], 1'b0};
                if (!rem_diff[W]) begin
                    rem_next  = rem_diff[W-1:0];
                    quot_next = {quot_reg[W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_shift[W-1:0];
                    quot_next = {quot_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(PW - 1)) begin
                    state_next = D_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    assign ctl.start = start;
    assign ctl.busy  = (state_reg != D_IDLE);
    assign ctl.done  = done_reg;
    assign quot      = quot_reg;
endmodule
`default_nettype wire

### src/ground_line_below_point_query.sv
// Ground line below a point: segment table with add, clear and query.
// An add, clear or unused op goes straight to a result beat. A query walks
// the stored segments one at a time; each segment is read and checked, and
// a segment whose x span holds the point (with distinct end x) also passes
// through the multiply/divide unit before the walk moves to the next one.
// The input is not ready until the result beat has been taken.
// Depends on glbpq_pkg, glbpq_muldiv and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ground_line_below_point_query_macros.svh"
module ground_line_below_point_query #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_WIDTH  = 24
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [glbpq_pkg::TOL_W-1:0]            cfg_data,   // below_tolerance
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // left_x, left_y, right_x, right_y, point_x, point_y
    input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    input  wire logic [glbpq_pkg::OP_W-1:0]             s_tuser,    // op
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [((COORD_WIDTH+7)/8)*8-1:0]            m_tdata,    // ground_y
    output logic [glbpq_pkg::STATUS_W-1:0]              m_tuser     // status
);
    import glbpq_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int W    = CW + 1;
    localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int NW   = $clog2(MAX_SEGMENTS + 1);
    localparam int FW   = CW + TOL_W + 2;
    localparam int SEGW = 4 * CW;
    localparam int MDW  = ((CW + 7) / 8) * 8;

    state_t              state_reg, state_next;
    logic [TOL_W-1:0]    tol_reg;
    logic [NW-1:0]       count_reg, count_next;
    logic [NW-1:0]       idx_reg, idx_next;
    logic                hit_reg, hit_next;
    logic [CW-1:0]       best_reg, best_next;
    logic [CW-1:0]       px_reg;
    logic [FW-1:0]       floor_reg;
    logic [CW-1:0]       ly_reg;
    logic                neg_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]       ydata_reg, ydata_next;
    logic [SEGW-1:0]     seg_mem [MAX_SEGMENTS];
    logic [SEGW-1:0]     rd_data_reg;
    logic                wr_en;
    logic                accept;
    op_t                 op_in;

    // checked segment fields
    logic signed [CW-1:0] lx, ly, rx, ry, px;
    logic signed [W-1:0]  dx, dy, off;
    logic [W-1:0]         mag;
    logic                 in_span;
    logic                 div_start;
    div_ctl_t             div_ctl;
    logic [W-1:0]         quot;
    logic signed [W:0]    y_full;
    logic signed [CW-1:0] y_new;
    logic                 qualifies;

    assign accept    = s_tvalid && s_tready;
    assign op_in     = op_t'(s_tuser);
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = MDW'(ydata_reg);
    assign m_tuser   = status_reg;

    // tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            tol_reg <= cfg_data;
        end
    end

    // segment table
    assign wr_en = accept && (op_in == OP_ADD) && (count_reg != NW'(MAX_SEGMENTS));
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            seg_mem[count_reg[IW-1:0]] <= s_tdata[SEGW-1:0];
        end
        rd_data_reg <= seg_mem[idx_reg[IW-1:0]];
    end

    // query operands held for the walk
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg    <= s_tdata[4*CW +: CW];
            floor_reg <= FW'($signed(s_tdata[5*CW +: CW])) - FW'(tol_reg);
        end
        if (div_start) begin
            ly_reg  <= ly;
            neg_reg <= dy[W-1];
        end
    end

    // span check and divider operands
    assign lx  = rd_data_reg[0    +: CW];
    assign ly  = rd_data_reg[CW   +: CW];
    assign rx  = rd_data_reg[2*CW +: CW];
    assign ry  = rd_data_reg[3*CW +: CW];
    assign px  = px_reg;
    assign dx  = W'(rx) - W'(lx);
    assign dy  = W'(ry) - W'(ly);
    assign off = W'(px) - W'(lx);
    assign mag = dy[W-1] ? W'(-dy) : W'(dy);
    assign in_span   = (px >= lx) && (px <= rx) && (rx != lx);
    assign div_start = (state_reg == S_CHECK) && in_span;

    glbpq_muldiv #(.W(W)) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (mag),
        .b       (off),
        .d       (dx),
        .ctl     (div_ctl),
        .quot    (quot)
    );

    // interpolated y and the acceptance test
    assign y_full    = neg_reg ? ((W+1)'($signed(ly_reg)) - $signed({1'b0, quot}))
                               : ((W+1)'($signed(ly_reg)) + $signed({1'b0, quot}));
    assign y_new     = y_full[CW-1:0];
    assign qualifies = ($signed(FW'(y_new)) >= $signed(floor_reg))
                       && (!hit_reg || (y_new <= $signed(best_reg)));

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
        end
        best_reg   <= best_next;
        status_reg <= status_next;
        ydata_reg  <= ydata_next;
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        best_next   = best_reg;
        status_next = status_reg;
        ydata_next  = ydata_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next = ST_OK;
                    ydata_next  = '0;
                    state_next  = S_OUT;
                    unique case (op_in)
                        OP_ADD: begin
                            if (count_reg == NW'(MAX_SEGMENTS)) status_next = ST_FULL;
                            else count_next = count_reg + 1'b1;
                        end
                        OP_CLEAR: count_next = '0;
                        OP_QUERY: begin
                            idx_next   = '0;
                            hit_next   = 1'b0;
                            state_next = (count_reg == '0) ? S_FINISH : S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: state_next = S_CHECK;
            S_CHECK: begin
                if (in_span) begin
                    state_next = S_DIV;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_next == count_reg) ? S_FINISH : S_READ;
                end
            end
            S_DIV: begin
                if (div_ctl.done) begin
                    if (qualifies) begin
                        hit_next  = 1'b1;
                        best_next = y_new;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_next == count_reg) ? S_FINISH : S_READ;
                end
            end
            S_FINISH: begin
                status_next = hit_reg ? ST_OK : ST_NOLINE;
                ydata_next  = hit_reg ? best_reg : '0;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // checks
    `GLBPQ_ASSERT(a_count_bound, (count_reg <= NW'(MAX_SEGMENTS)), "segment count overflow")
    `GLBPQ_ASSERT(a_one_side, !(s_tready && m_tvalid), "input ready while result pending")
    `GLBPQ_ASSERT(a_full_flag, (accept && op_in == OP_ADD && count_reg == NW'(MAX_SEGMENTS)) |=> (m_tvalid && m_tuser == ST_FULL), "full add not flagged")
    `GLBPQ_ASSERT(a_div_owner, div_ctl.busy |-> (state_reg == S_DIV), "divider busy outside query walk")
endmodule
`default_nettype wire
